@@ hw/rtl/binc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binc_pkg
// shared types and constants of the binary image neighbor count block
// ----------------------------------------------------------------------------
package binc_pkg;

  localparam int POS_W       = 7;   // row and column fields of a result
  localparam int CNT_W       = 4;   // neighbor count field
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int WIN_W       = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // item kinds on in_tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // per item control from the sequencer to the window
  typedef struct packed {
    logic proc;      // item takes part in the frame
    logic emit;      // item releases a result
    logic last;      // released result closes the frame
    logic restart;   // window goes back to zeros
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
  } ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             is_one;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

endpackage

@@ hw/rtl/binary_image_neighbor_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_neighbor_count
// streaming neighbor count of a binary image (minesweeper numbers)
// ----------------------------------------------------------------------------
// usage
// - in_ stream: one request per pixel in raster order, in_tdata[0] the pixel,
//   in_tuser 0 for a pixel, 1 for a flush tick; after the last pixel of a
//   frame send width + 1 flush ticks to drain the pending results
// - out_ stream: one result per pixel, row, column, star flag and count;
//   out_tlast marks the final pixel of the frame
// - cfg_ port: index 0 image width, index 1 image height; always ready,
//   a write to either restarts the frame; write only while the block is idle
// - a result leaves on the request that comes one row plus one pixel after
//   its pixel, and shows on out_ in the cycle after that request is taken
// - one request per cycle while out_ is not stalled; the line store is fetched
//   one column ahead into a register so its read port never holds up the stream
// - reset clears counters and window and sets the dimensions to 128 x 128;
//   the line store needs no clearing pass
// - a stalled receiver holds the output register; in_tready stays high as
//   long as the output register is free or being taken
// ----------------------------------------------------------------------------
module binary_image_neighbor_count #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [binc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] pixel_bit, rest zero
  input  logic                             in_tuser,   // [0] func
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [binc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [6:0] out_row, [13:7] out_col,
                                                        // [14] is_one,
                                                        // [18:15] neighbor_count, rest zero
  output logic                             out_tlast,  // frame_last
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [binc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [binc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  binc_pkg::ctl_t             ctl;
  binc_pkg::res_t             res;
  binc_pkg::res_t             res_r;
  logic                       out_valid_r;
  logic                       in_accept;
  logic                       produce;
  logic                       px;
  logic [CW-1:0]              col_r;
  logic [CW-1:0]              col_nxt;
  logic [1:0]                 rd_data_r;
  logic [binc_pkg::POS_W-1:0] pos_row;
  logic [binc_pkg::POS_W-1:0] pos_col;

  assign cfg_ready = 1'b1;
  // output register frees up when it is empty or taken this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  // flush ticks shift zeros into the stores and window
  assign px        = (in_tuser == binc_pkg::FUNC_FLUSH) ? 1'b0 : in_tdata[0];
  assign produce   = ctl.proc && ctl.emit;

  binc_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_accept(in_accept),
    .in_func  (in_tuser),
    .ctl      (ctl),
    .col_r    (col_r),
    .col_nxt  (col_nxt),
    .pos_row  (pos_row),
    .pos_col  (pos_col)
  );

  // older row moves on as the newer row is replaced by the current pixel
  binc_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .wr_en    (ctl.proc),
    .wr_addr  (col_r),
    .wr_data  ({px, rd_data_r[1]}),
    .rd_addr  (col_nxt),
    .rd_data_r(rd_data_r)
  );

  binc_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .px     (px),
    .top    (rd_data_r[0]),
    .mid    (rd_data_r[1]),
    .pos_row(pos_row),
    .pos_col(pos_col),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.count, res_r.is_one, res_r.col, res_r.row};
  assign out_tlast  = res_r.last;

  // a star never carries a count
  a_star_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.is_one |-> res_r.count == '0)
    else $error("star result with nonzero count");

  // at most eight neighbors
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_r.count <= 4'd8)
    else $error("neighbor count above eight");

  // a released result is presented on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_tvalid)
    else $error("released result not presented");

  // only accepted requests can release a result
  a_release_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    produce |-> in_tvalid && in_tready)
    else $error("result released without an accepted request");

endmodule

@@ hw/rtl/binc_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binc_line_store
// two row stores in one memory, read one column ahead with a write bypass
// ----------------------------------------------------------------------------
module binc_line_store #(
  parameter int MAX_WIDTH = 128
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [1:0]                   wr_data,   // bit 0 older row, bit 1 newer row
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [1:0]                   rd_data_r
);

  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same address written and fetched at one edge: take the new word
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/binc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binc_seq
// dimension registers, input and result position counters, frame control
// ----------------------------------------------------------------------------
module binc_seq #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr,
  input  logic [binc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [binc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_accept,
  input  logic                            in_func,
  output binc_pkg::ctl_t                  ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]    col_r,
  output logic [$clog2(MAX_WIDTH)-1:0]    col_nxt,
  output logic [binc_pkg::POS_W-1:0]      pos_row,
  output logic [binc_pkg::POS_W-1:0]      pos_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [binc_pkg::CFG_DATA_W-1:0] width_cfg_r, width_cfg_nxt;
  logic [binc_pkg::CFG_DATA_W-1:0] height_cfg_r, height_cfg_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] em_col_r, em_col_nxt;
  logic [RW-1:0] em_row_r, em_row_nxt;
  logic          frame_done_r, frame_done_nxt;

  logic [WW-1:0] w;
  logic [RW-1:0] h;
  logic [WW-1:0] col_inc, em_col_inc;
  logic [RW-1:0] row_inc, em_row_inc;
  logic          cfg_restart;

  // clamp dimensions to the legal range
  always_comb begin
    priority if (width_cfg_r < 8'd2) begin
      w = WW'(2);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_cfg_r);
    end
    priority if (height_cfg_r < 8'd2) begin
      h = RW'(2);
    end else if (32'(height_cfg_r) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(height_cfg_r);
    end
  end

  assign col_inc    = WW'(col_r) + WW'(1);
  assign row_inc    = row_r + RW'(1);
  assign em_col_inc = WW'(em_col_r) + WW'(1);
  assign em_row_inc = em_row_r + RW'(1);

  assign cfg_restart = cfg_wr &&
                       ((cfg_index == binc_pkg::REG_IMAGE_WIDTH) ||
                        (cfg_index == binc_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    ctl.proc     = in_accept && (in_func == frame_done_r);
    ctl.emit     = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    ctl.left_ok  = (em_col_r != '0);
    ctl.right_ok = (em_col_inc < w);
    ctl.top_ok   = (em_row_r != '0);
    ctl.bot_ok   = (em_row_inc < h);
    ctl.last     = !ctl.bot_ok && !ctl.right_ok;
    ctl.restart  = cfg_restart || (ctl.proc && ctl.emit && ctl.last);
  end

  always_comb begin
    width_cfg_nxt  = width_cfg_r;
    height_cfg_nxt = height_cfg_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    em_col_nxt     = em_col_r;
    em_row_nxt     = em_row_r;
    frame_done_nxt = frame_done_r;
    if (cfg_wr && (cfg_index == binc_pkg::REG_IMAGE_WIDTH)) begin
      width_cfg_nxt = cfg_data;
    end
    if (cfg_wr && (cfg_index == binc_pkg::REG_IMAGE_HEIGHT)) begin
      height_cfg_nxt = cfg_data;
    end
    if (ctl.proc) begin
      if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = row_inc;
        if ((in_func == binc_pkg::FUNC_PIXEL) && (row_inc >= h)) begin
          frame_done_nxt = 1'b1;
        end
      end else begin
        col_nxt = CW'(col_inc);
      end
      if (ctl.emit && !ctl.last) begin
        if (em_col_inc >= w) begin
          em_col_nxt = '0;
          em_row_nxt = em_row_inc;
        end else begin
          em_col_nxt = CW'(em_col_inc);
        end
      end
    end
    if (ctl.restart) begin
      col_nxt        = '0;
      row_nxt        = '0;
      em_col_nxt     = '0;
      em_row_nxt     = '0;
      frame_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= 8'd128;
      height_cfg_r <= 8'd128;
      col_r        <= '0;
      row_r        <= '0;
      em_col_r     <= '0;
      em_row_r     <= '0;
      frame_done_r <= 1'b0;
    end else begin
      width_cfg_r  <= width_cfg_nxt;
      height_cfg_r <= height_cfg_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      em_col_r     <= em_col_nxt;
      em_row_r     <= em_row_nxt;
      frame_done_r <= frame_done_nxt;
    end
  end

  assign pos_row = binc_pkg::POS_W'(em_row_r);
  assign pos_col = binc_pkg::POS_W'(em_col_r);

endmodule

@@ hw/rtl/binc_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binc_window
// 3x3 window register and masked neighbor count
// ----------------------------------------------------------------------------
module binc_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  binc_pkg::ctl_t             ctl,
  input  logic                       px,
  input  logic                       top,
  input  logic                       mid,
  input  logic [binc_pkg::POS_W-1:0] pos_row,
  input  logic [binc_pkg::POS_W-1:0] pos_col,
  output binc_pkg::res_t             res
);

  // bits 6..8 left column, 3..5 center, 0..2 right; in each column
  // lowest bit top row, highest bit bottom row
  logic [binc_pkg::WIN_W-1:0] win_r;
  logic [binc_pkg::WIN_W-1:0] win_nxt;
  logic [binc_pkg::WIN_W-1:0] mask;
  logic [binc_pkg::CNT_W-1:0] sum;

  assign win_nxt = {win_r[5:0], px, mid, top};

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int rr = 0; rr < 3; rr++) begin
        mask[g*3+rr] = ((g == 0) ? ctl.right_ok : (g == 2) ? ctl.left_ok : 1'b1) &&
                       ((rr == 0) ? ctl.top_ok : (rr == 2) ? ctl.bot_ok : 1'b1);
      end
    end
    mask[4] = 1'b0;  // the pixel itself
    sum = '0;
    for (int i = 0; i < binc_pkg::WIN_W; i++) begin
      sum = sum + binc_pkg::CNT_W'(win_nxt[i] & mask[i]);
    end
  end

  always_comb begin
    res.row    = pos_row;
    res.col    = pos_col;
    res.is_one = win_nxt[4];
    res.count  = win_nxt[4] ? '0 : sum;
    res.last   = ctl.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.restart) begin
      win_r <= '0;
    end else if (ctl.proc) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ bench/tb_binary_image_neighbor_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_image_neighbor_count
// self-checking bench: streams binary frames of many sizes through the block
// and compares every result (row, column, star flag, count, frame end) with
// a cycle-free image tracker kept in the bench, under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_binary_image_neighbor_count;

  localparam int MAX_DIM     = 128;
  localparam int IDLE_LIMIT  = 1000;   // cycles without any handshake
  localparam int DRAIN_WAIT  = 4;      // extra wait after the drain before a register write
  localparam int MAX_REPORTS = 20;
  localparam int ITEM_TARGET = 1100;   // requests for the whole run
  localparam logic [binc_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;   // no register here

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [binc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // [0] pixel_bit, rest zero
  logic                             in_tuser   = 1'b0; // [0] func
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [binc_pkg::OUT_TDATA_W-1:0] out_tdata;         // [6:0] row, [13:7] col,
                                                       // [14] is_one,
                                                       // [18:15] neighbor_count
  logic                             out_tlast;         // frame_last
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [binc_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [binc_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  binary_image_neighbor_count i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // image tracker: own copy of registers, line stores, window and counters
  // --------------------------------------------------------------------------
  logic [7:0] width_reg  = 8'd128;
  logic [7:0] height_reg = 8'd128;
  logic       older_line [MAX_DIM];
  logic       newer_line [MAX_DIM];
  logic [8:0] window;
  int         in_row, in_col, res_row, res_col;
  logic       frame_full;

  binc_pkg::res_t pending_cells[$];   // results owed by the block, oldest first

  int mismatches    = 0;
  int results_seen  = 0;
  int pixels_sent   = 0;
  int frames_sent   = 0;
  int burst_left    = 0;
  int requests_sent = 0;

  function automatic int clamp_dim(input logic [7:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic void clear_frame();
    window     = '0;
    in_row     = 0;
    in_col     = 0;
    res_row    = 0;
    res_col    = 0;
    frame_full = 1'b0;
  endfunction

  function automatic void apply_register(input logic [binc_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [binc_pkg::CFG_DATA_W-1:0] value);
    if (idx == binc_pkg::REG_IMAGE_WIDTH) begin
      width_reg = value;
      clear_frame();
    end else if (idx == binc_pkg::REG_IMAGE_HEIGHT) begin
      height_reg = value;
      clear_frame();
    end
  endfunction

  // one accepted request: shift the window and queue the result it releases
  function automatic void advance_image(input logic func, input logic pix);
    int   w, h, c, count;
    logic flush, bit_in, top_bit, mid_bit, releases;
    logic left_ok, right_ok, top_ok, bot_ok, col_ok, row_ok;
    binc_pkg::res_t item;
    w      = clamp_dim(width_reg);
    h      = clamp_dim(height_reg);
    flush  = (func == binc_pkg::FUNC_FLUSH);
    bit_in = flush ? 1'b0 : pix;
    // flush only counts once all pixels are in; pixels only before that
    if (flush != frame_full) return;
    c = in_col;
    top_bit = older_line[c];
    mid_bit = newer_line[c];
    older_line[c] = mid_bit;
    newer_line[c] = bit_in;
    // newest column in bits 0..2: top row, middle row, bottom row
    window = {window[5:0], bit_in, mid_bit, top_bit};
    releases = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (!flush && in_row >= h) frame_full = 1'b1;
    end
    if (!releases) return;

    left_ok  = res_col > 0;
    right_ok = res_col + 1 < w;
    top_ok   = res_row > 0;
    bot_ok   = res_row + 1 < h;
    count    = 0;
    for (int g = 0; g < 3; g++) begin
      for (int rr = 0; rr < 3; rr++) begin
        col_ok = (g == 0) ? right_ok : (g == 2) ? left_ok : 1'b1;
        row_ok = (rr == 0) ? top_ok : (rr == 2) ? bot_ok : 1'b1;
        if (col_ok && row_ok && !(g == 1 && rr == 1)) count += window[g*3+rr];
      end
    end
    item.row    = binc_pkg::POS_W'(res_row);
    item.col    = binc_pkg::POS_W'(res_col);
    item.is_one = window[4];
    item.count  = window[4] ? '0 : binc_pkg::CNT_W'(count);
    item.last   = (res_row + 1 >= h) && (res_col + 1 >= w);
    pending_cells.push_back(item);
    if (item.last) begin
      clear_frame();
    end else begin
      res_col++;
      if (res_col >= w) begin
        res_col = 0;
        res_row++;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps in between
  // --------------------------------------------------------------------------
  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_request(input logic func, input logic pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(binc_pkg::IN_TDATA_W-1){1'b0}}, pix};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    advance_image(func, pix);
  endtask

  // sender holds off until the block owes nothing
  task automatic wait_drained();
    idle_input();
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_register(input logic [binc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [binc_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame at the current size: send_count pixels, then the drain ticks
  // when the frame is whole; noisy adds stray flushes and stray pixels
  task automatic send_frame(input int density, input bit noisy,
                            input int send_count, input int pause_at);
    int w, h;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    for (int i = 0; i < send_count; i++) begin
      if (i == pause_at) wait_drained();
      if (noisy && $urandom_range(0, 19) == 0)
        send_request(binc_pkg::FUNC_FLUSH, 1'($urandom()));
      send_request(binc_pkg::FUNC_PIXEL, $urandom_range(0, 99) < density);
    end
    pixels_sent += send_count;
    if (send_count < w * h) return;
    for (int k = 0; k < w + 1; k++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        send_request(binc_pkg::FUNC_PIXEL, 1'($urandom()));
      send_request(binc_pkg::FUNC_FLUSH, 1'($urandom()));
    end
    frames_sent++;
  endtask

  // --------------------------------------------------------------------------
  // receiver: stall pattern redrawn each time the phase counter wraps, some windows stall-free
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_phase   = 0;

  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
    out_tready <= stall_pattern[stall_phase % 16];
    stall_phase = (stall_phase + 1) % 64;
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR result %0d: %s got %0d, want %0d", results_seen, field, got, want);
  endtask

  binc_pkg::res_t want_cell;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("result with none owed, row", out_tdata[binc_pkg::POS_W-1:0], 0);
      end else begin
        want_cell = pending_cells.pop_front();
        if (out_tdata[binc_pkg::POS_W-1:0] != want_cell.row)
          report_mismatch("row", out_tdata[binc_pkg::POS_W-1:0], want_cell.row);
        if (out_tdata[2*binc_pkg::POS_W-1:binc_pkg::POS_W] != want_cell.col)
          report_mismatch("col", out_tdata[2*binc_pkg::POS_W-1:binc_pkg::POS_W],
                          want_cell.col);
        if (out_tdata[2*binc_pkg::POS_W] != want_cell.is_one)
          report_mismatch("is_one", out_tdata[2*binc_pkg::POS_W], want_cell.is_one);
        if (out_tdata[2*binc_pkg::POS_W+binc_pkg::CNT_W:2*binc_pkg::POS_W+1] !=
            want_cell.count)
          report_mismatch("neighbor_count",
                          out_tdata[2*binc_pkg::POS_W+binc_pkg::CNT_W:2*binc_pkg::POS_W+1],
                          want_cell.count);
        if (out_tlast != want_cell.last)
          report_mismatch("frame_last", out_tlast, want_cell.last);
      end
      results_seen++;
    end
  end

  // watchdog: a stretch without a handshake on any port that reaches IDLE_LIMIT ends the run
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
      $display("binary_image_neighbor_count: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset size is 128 x 128: a row and a few pixels release the first results
  task automatic test_reset_dimensions();
    for (int i = 0; i < MAX_DIM + 4; i++)
      send_request(binc_pkg::FUNC_PIXEL, 1'($urandom()));
  endtask

  // writes in the middle of the frame start a new one; then a ring of stars
  // around a zero center gives the largest count
  task automatic test_write_restarts();
    logic [8:0] ring;
    ring = 9'b111_101_111;
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd3);
    send_request(binc_pkg::FUNC_PIXEL, 1'b1);
    send_request(binc_pkg::FUNC_PIXEL, 1'b0);
    write_register(binc_pkg::REG_IMAGE_HEIGHT, 8'd3);
    for (int i = 0; i < 9; i++) send_request(binc_pkg::FUNC_PIXEL, ring[i]);
    for (int k = 0; k < 4; k++) send_request(binc_pkg::FUNC_FLUSH, 1'b0);
    frames_sent++;
  endtask

  // 2 x 2 frame: flushes before the frame is whole and pixels during the
  // drain are dropped
  task automatic test_stray_requests();
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd2);
    write_register(binc_pkg::REG_IMAGE_HEIGHT, 8'd2);
    send_request(binc_pkg::FUNC_FLUSH, 1'b1);
    send_request(binc_pkg::FUNC_PIXEL, 1'b0);
    send_request(binc_pkg::FUNC_PIXEL, 1'b1);
    send_request(binc_pkg::FUNC_FLUSH, 1'b0);
    send_request(binc_pkg::FUNC_PIXEL, 1'b0);
    send_request(binc_pkg::FUNC_PIXEL, 1'b0);
    send_request(binc_pkg::FUNC_PIXEL, 1'b1);
    send_request(binc_pkg::FUNC_FLUSH, 1'b0);
    send_request(binc_pkg::FUNC_PIXEL, 1'b1);
    send_request(binc_pkg::FUNC_FLUSH, 1'b1);
    send_request(binc_pkg::FUNC_FLUSH, 1'b0);
    send_request(binc_pkg::FUNC_FLUSH, 1'b0);   // frame already closed
    frames_sent++;
  endtask

  // sizes below 2 act as 2, above 128 act as 128; unknown index is ignored
  task automatic test_dimension_clamps();
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd0);
    write_register(binc_pkg::REG_IMAGE_HEIGHT, 8'd255);
    send_frame(50, 1'b0, 2 * MAX_DIM, -1);
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd1);
    write_register(binc_pkg::REG_IMAGE_HEIGHT, 8'd0);
    send_frame(100, 1'b0, 4, -1);
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd255);
    write_register(binc_pkg::REG_IMAGE_HEIGHT, 8'd2);
    send_frame(40, 1'b0, 2 * MAX_DIM, -1);
    // 3 x 2 frame must survive a write to an unused index
    write_register(binc_pkg::REG_IMAGE_WIDTH, 8'd3);
    write_register(REG_SPARE, 8'hFF);
    send_frame(30, 1'b0, 3 * 2, -1);
  endtask

  // mostly small frames of random size and density, with noise, cut frames
  // and a pause until the block owes nothing
  task automatic test_random_frames();
    int w, h, cells, cut, pause_at;
    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        write_register(binc_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                       8'($urandom_range(11, 20)) : 8'($urandom_range(2, 10)));
        write_register(binc_pkg::REG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0) ?
                       8'($urandom_range(11, 20)) : 8'($urandom_range(2, 10)));
      end
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      cells = w * h;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cells - 1) : cells;
      pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cut - 1) : -1;
      send_frame($urandom_range(0, 100), 1'b1, cut, pause_at);
      // a cut frame is abandoned by a register write
      if (cut < cells) write_register(binc_pkg::REG_IMAGE_WIDTH, width_reg);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_DIM; i++) begin
      older_line[i] = 1'b0;
      newer_line[i] = 1'b0;
    end
    clear_frame();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_dimensions();
    test_write_restarts();
    test_stray_requests();
    test_dimension_clamps();
    test_random_frames();

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d frames, %0d pixels, %0d results checked", frames_sent,
             pixels_sent, results_seen);
    $display("sizes 2 to 128 with clamping, stray requests, restarts, gaps and stalls");
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("binary_image_neighbor_count: match");
    end else begin
      $display("binary_image_neighbor_count: mismatch");
    end
    $finish;
  end

endmodule
